### sv/tces_pkg.sv
// ----------------------------------------------------------------------------
// tces_pkg: shared types and constants of the tolerance compare unit
// Field widths, command and category codes, and the item passed from the
// front end to the statistics back end.
// ----------------------------------------------------------------------------
package tces_pkg;

	localparam int SAMPLE_BITS_DEF = 32;
	localparam int POINT_BITS_DEF  = 12;
	localparam int SUB_BITS_DEF    = 6;
	localparam int QUEUE_DEPTH     = 4;

	localparam int CMD_W    = 2;
	localparam int CAT_W    = 2;
	localparam int POINT_W  = 12;
	localparam int SUB_W    = 6;
	localparam int SAMPLE_W = 32;
	localparam int DELTA_W  = 32;
	localparam int COUNT_W  = 32;
	localparam int SUM_W    = 64;
	localparam int SDELTA_W = 33;
	localparam int TOL_W    = 32;
	localparam int NCAT     = 3;

	localparam int S_TDATA_W = 152;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = 216;

	localparam logic [CMD_W-1:0] CMD_COMPARE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

	localparam logic [CAT_W-1:0] CAT_RAW   = 2'd0;
	localparam logic [CAT_W-1:0] CAT_COMP  = 2'd1;
	localparam logic [CAT_W-1:0] CAT_TOTAL = 2'd3;

	localparam logic [TOL_W-1:0] TOL_RESET = 32'd1;

	typedef enum logic [1:0] {
		OP_COMPARE,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef enum logic [2:0] {
		ST_MATCH = 3'd0,
		ST_TOL   = 3'd1,
		ST_CLIP  = 3'd2,
		ST_HALT  = 3'd3,
		ST_DONE  = 3'd4
	} status_t;

	// input beat, last member in the lowest bits
	typedef struct packed {
		logic [3:0]          pad;
		logic                actual_clip;
		logic                expected_clip;
		logic [SAMPLE_W-1:0] actual_im;
		logic [SAMPLE_W-1:0] actual_re;
		logic [SAMPLE_W-1:0] expected_im;
		logic [SAMPLE_W-1:0] expected_re;
		logic [SUB_W-1:0]    sub_index;
		logic [POINT_W-1:0]  point_index;
	} in_beat_t;

	typedef struct packed {
		logic [CAT_W-1:0] category;
		logic [CMD_W-1:0] cmd;
	} in_user_t;

	// classified item handed from front to back
	typedef struct packed {
		op_t                 op;
		logic [CAT_W-1:0]    cat;
		status_t             verdict;
		logic [POINT_W-1:0]  point;
		logic [SUB_W-1:0]    sub;
		logic [DELTA_W-1:0]  delta;
		logic [SDELTA_W-1:0] sdelta;
		logic                is_real;
		logic [SUM_W-1:0]    square;
	} item_t;

	// result beat, last member in the lowest bits
	typedef struct packed {
		logic [SDELTA_W-1:0] max_signed_delta;
		logic                max_is_real;
		logic [SUB_W-1:0]    max_sub;
		logic [POINT_W-1:0]  max_point;
		logic [DELTA_W-1:0]  max_delta;
		logic                has_max;
		logic [SUM_W-1:0]    square_sum;
		logic [COUNT_W-1:0]  sample_count;
		logic [DELTA_W-1:0]  sample_delta;
		status_t             status;
	} result_t;

endpackage

### sv/tces_front.sv
// ----------------------------------------------------------------------------
// tces_front: input classification pipeline
// Takes input beats, forms the I/Q differences, checks tolerance and clip
// flags, picks the dominant component and squares it over three stages.
// ----------------------------------------------------------------------------
module tces_front #(
	parameter int SAMPLE_BITS = tces_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tces_pkg::TOL_W-1:0]       cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tces_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [tces_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                             item_valid,
	input  logic                             item_ready,
	output tces_pkg::item_t                  item
);

	tces_pkg::in_beat_t beat;
	tces_pkg::in_user_t user;
	logic [tces_pkg::TOL_W-1:0] tolerance_q;

	logic adv_s1, adv_s2, adv_s3;
	logic v_s1, v_s2, v_s3;

	tces_pkg::op_t                   op_s1;
	logic [tces_pkg::CAT_W-1:0]      cat_s1;
	logic [tces_pkg::POINT_W-1:0]    point_s1;
	logic [tces_pkg::SUB_W-1:0]      sub_s1;
	logic                            clip_bad_s1;
	logic signed [SAMPLE_BITS:0]     dre_s1, dim_s1;

	tces_pkg::item_t item_s2, item_s3, item_d2, item_d3;

	tces_pkg::op_t                   op_d1;
	logic signed [SAMPLE_BITS:0]     er_x, ei_x, ar_x, ai_x;
	logic signed [SAMPLE_BITS:0]     neg_re, neg_im, mag_re, mag_im, sel_d;
	logic [tces_pkg::DELTA_W-1:0]    are, aim;
	logic                            re_dom;

	assign beat = tces_pkg::in_beat_t'(s_tdata);
	assign user = tces_pkg::in_user_t'(s_tuser);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= tces_pkg::TOL_RESET;
		end else if (cfg_valid) begin
			tolerance_q <= cfg_data;
		end
	end

	assign adv_s3   = !v_s3 || item_ready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign s_tready = adv_s1;

	// stage 1: classify command, sign-extend and subtract
	always_comb begin
		priority if (user.cmd == tces_pkg::CMD_CLEAR) begin
			op_d1 = tces_pkg::OP_CLEAR;
		end else if (user.cmd == tces_pkg::CMD_COMPARE && user.category != tces_pkg::CAT_TOTAL) begin
			op_d1 = tces_pkg::OP_COMPARE;
		end else begin
			op_d1 = tces_pkg::OP_READ;
		end
	end

	assign er_x = {beat.expected_re[SAMPLE_BITS-1], beat.expected_re[SAMPLE_BITS-1:0]};
	assign ei_x = {beat.expected_im[SAMPLE_BITS-1], beat.expected_im[SAMPLE_BITS-1:0]};
	assign ar_x = {beat.actual_re[SAMPLE_BITS-1], beat.actual_re[SAMPLE_BITS-1:0]};
	assign ai_x = {beat.actual_im[SAMPLE_BITS-1], beat.actual_im[SAMPLE_BITS-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			op_s1       <= op_d1;
			cat_s1      <= user.category;
			point_s1    <= beat.point_index;
			sub_s1      <= beat.sub_index;
			clip_bad_s1 <= (user.category == tces_pkg::CAT_RAW ||
				user.category == tces_pkg::CAT_COMP) &&
				(beat.expected_clip ^ beat.actual_clip);
			dre_s1      <= ar_x - er_x;
			dim_s1      <= ai_x - ei_x;
		end
	end

	// stage 2: magnitudes, dominant component, verdict
	assign neg_re = -dre_s1;
	assign neg_im = -dim_s1;
	assign mag_re = dre_s1[SAMPLE_BITS] ? neg_re : dre_s1;
	assign mag_im = dim_s1[SAMPLE_BITS] ? neg_im : dim_s1;
	assign are    = tces_pkg::DELTA_W'(mag_re[SAMPLE_BITS-1:0]);
	assign aim    = tces_pkg::DELTA_W'(mag_im[SAMPLE_BITS-1:0]);
	assign re_dom = are >= aim;
	assign sel_d  = re_dom ? dre_s1 : dim_s1;

	always_comb begin
		item_d2         = '0;
		item_d2.op      = op_s1;
		item_d2.cat     = cat_s1;
		item_d2.point   = point_s1;
		item_d2.sub     = sub_s1;
		item_d2.is_real = re_dom;
		item_d2.delta   = re_dom ? are : aim;
		item_d2.sdelta  = tces_pkg::SDELTA_W'(sel_d);
		priority if (clip_bad_s1) begin
			item_d2.verdict = tces_pkg::ST_CLIP;
		end else if (tolerance_q == '0 || are > tolerance_q || aim > tolerance_q) begin
			item_d2.verdict = tces_pkg::ST_TOL;
		end else begin
			item_d2.verdict = tces_pkg::ST_MATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// stage 3: square the dominant delta
	always_comb begin
		item_d3        = item_s2;
		item_d3.square = tces_pkg::SUM_W'(item_s2.delta) * tces_pkg::SUM_W'(item_s2.delta);
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			item_s2 <= item_d2;
		end
		if (adv_s3 && v_s2) begin
			item_s3 <= item_d3;
		end
	end

	assign item_valid = v_s3;
	assign item       = item_s3;

endmodule

### sv/tces_fifo.sv
// ----------------------------------------------------------------------------
// tces_fifo: short queue between front end and back end
// Register-based first-in first-out buffer with valid/ready on both sides.
// ----------------------------------------------------------------------------
module tces_fifo #(
	parameter int WIDTH = $bits(tces_pkg::item_t),
	parameter int DEPTH = tces_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign wr_ready = count_q != CNT_W'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/tces_back.sv
// ----------------------------------------------------------------------------
// tces_back: statistics update and result register
// Applies the sticky halt, updates the per-category and total statistics
// for matching pairs, and registers one result beat per item.
// ----------------------------------------------------------------------------
module tces_back #(
	parameter int POINT_BITS = tces_pkg::POINT_BITS_DEF,
	parameter int SUB_BITS   = tces_pkg::SUB_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  tces_pkg::item_t                item,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tces_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int NC = tces_pkg::NCAT;

	logic [tces_pkg::COUNT_W-1:0]  cnt_q    [NC];
	logic [tces_pkg::SUM_W-1:0]    sum_q    [NC];
	logic                          has_q    [NC];
	logic [tces_pkg::DELTA_W-1:0]  maxd_q   [NC];
	logic [POINT_BITS-1:0]         maxpt_q  [NC];
	logic [SUB_BITS-1:0]           maxsub_q [NC];
	logic                          maxre_q  [NC];
	logic [tces_pkg::SDELTA_W-1:0] maxsd_q  [NC];
	logic [tces_pkg::COUNT_W-1:0]  tot_cnt_q;
	logic [tces_pkg::SUM_W-1:0]    tot_sum_q;
	logic [tces_pkg::DELTA_W-1:0]  tot_max_q;
	logic                          halted_q;

	logic                          out_valid_q;
	tces_pkg::result_t             out_q;
	tces_pkg::result_t             res;

	logic                          fire, is_cat, is_cmp, pass, fail, take_max;
	logic [1:0]                    idx;
	logic [tces_pkg::COUNT_W-1:0]  new_cnt, new_tot_cnt;
	logic [tces_pkg::SUM_W:0]      sum_x, tot_sum_x;
	logic [tces_pkg::SUM_W-1:0]    new_sum, new_tot_sum;
	logic [tces_pkg::DELTA_W-1:0]  new_tot_max;
	logic                          any_has;

	assign item_ready = !out_valid_q || m_tready;
	assign fire       = item_valid && item_ready;

	assign is_cat = item.cat != tces_pkg::CAT_TOTAL;
	assign idx    = is_cat ? item.cat : 2'd0;
	assign is_cmp = item.op == tces_pkg::OP_COMPARE;
	assign pass   = is_cmp && !halted_q && item.verdict == tces_pkg::ST_MATCH;
	assign fail   = is_cmp && !halted_q && item.verdict != tces_pkg::ST_MATCH;

	// saturating count and sum, strict-greater maximum
	assign new_cnt     = (cnt_q[idx] == '1) ? cnt_q[idx] : cnt_q[idx] + 1'b1;
	assign new_tot_cnt = (tot_cnt_q == '1) ? tot_cnt_q : tot_cnt_q + 1'b1;
	assign sum_x       = {1'b0, sum_q[idx]} + {1'b0, item.square};
	assign tot_sum_x   = {1'b0, tot_sum_q} + {1'b0, item.square};
	assign new_sum     = sum_x[tces_pkg::SUM_W] ? '1 : sum_x[tces_pkg::SUM_W-1:0];
	assign new_tot_sum = tot_sum_x[tces_pkg::SUM_W] ? '1 : tot_sum_x[tces_pkg::SUM_W-1:0];
	assign take_max    = !has_q[idx] || item.delta > maxd_q[idx];
	assign new_tot_max = (item.delta > tot_max_q) ? item.delta : tot_max_q;
	assign any_has     = has_q[0] || has_q[1] || has_q[2] || pass;

	always_comb begin
		res = '0;
		if (is_cmp) begin
			res.status       = halted_q ? tces_pkg::ST_HALT : item.verdict;
			res.sample_delta = halted_q ? '0 : item.delta;
		end else begin
			res.status = tces_pkg::ST_DONE;
		end
		res.max_is_real = 1'b1;
		if (item.op != tces_pkg::OP_CLEAR) begin
			if (is_cat) begin
				res.sample_count = pass ? new_cnt : cnt_q[idx];
				res.square_sum   = pass ? new_sum : sum_q[idx];
				res.has_max      = pass || has_q[idx];
				if (pass && take_max) begin
					res.max_delta        = item.delta;
					res.max_point        = tces_pkg::POINT_W'(POINT_BITS'(item.point));
					res.max_sub          = tces_pkg::SUB_W'(SUB_BITS'(item.sub));
					res.max_is_real      = item.is_real;
					res.max_signed_delta = item.sdelta;
				end else begin
					res.max_delta        = maxd_q[idx];
					res.max_point        = tces_pkg::POINT_W'(maxpt_q[idx]);
					res.max_sub          = tces_pkg::SUB_W'(maxsub_q[idx]);
					res.max_is_real      = maxre_q[idx];
					res.max_signed_delta = maxsd_q[idx];
				end
			end else begin
				res.sample_count = tot_cnt_q;
				res.square_sum   = tot_sum_q;
				res.has_max      = any_has;
				res.max_delta    = tot_max_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NC; c++) begin
				cnt_q[c]    <= '0;
				sum_q[c]    <= '0;
				has_q[c]    <= 1'b0;
				maxd_q[c]   <= '0;
				maxpt_q[c]  <= '0;
				maxsub_q[c] <= '0;
				maxre_q[c]  <= 1'b1;
				maxsd_q[c]  <= '0;
			end
			tot_cnt_q <= '0;
			tot_sum_q <= '0;
			tot_max_q <= '0;
			halted_q  <= 1'b0;
		end else if (fire) begin
			if (item.op == tces_pkg::OP_CLEAR) begin
				for (int c = 0; c < NC; c++) begin
					cnt_q[c]    <= '0;
					sum_q[c]    <= '0;
					has_q[c]    <= 1'b0;
					maxd_q[c]   <= '0;
					maxpt_q[c]  <= '0;
					maxsub_q[c] <= '0;
					maxre_q[c]  <= 1'b1;
					maxsd_q[c]  <= '0;
				end
				tot_cnt_q <= '0;
				tot_sum_q <= '0;
				tot_max_q <= '0;
				halted_q  <= 1'b0;
			end else if (pass) begin
				cnt_q[idx] <= new_cnt;
				sum_q[idx] <= new_sum;
				has_q[idx] <= 1'b1;
				if (take_max) begin
					maxd_q[idx]   <= item.delta;
					maxpt_q[idx]  <= POINT_BITS'(item.point);
					maxsub_q[idx] <= SUB_BITS'(item.sub);
					maxre_q[idx]  <= item.is_real;
					maxsd_q[idx]  <= item.sdelta;
				end
				tot_cnt_q <= new_tot_cnt;
				tot_sum_q <= new_tot_sum;
				tot_max_q <= new_tot_max;
			end else if (fail) begin
				halted_q <= 1'b1;
			end
		end
	end

	// result register: load while empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_ready) begin
			out_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

### sv/tolerance_compare_error_stats_unit.sv
// ----------------------------------------------------------------------------
// tolerance_compare_error_stats_unit: tolerance compare with error statistics
// Compares expected and actual I/Q sample pairs and keeps per-category and
// total error statistics, with a sticky halt on the first failure.
// ----------------------------------------------------------------------------
// Path: an input beat passes three front stages, one queue slot and the
// result register before its result beat is valid.
// Throughput: one beat per cycle while m_tready allows; the statistics update
// is a read-modify-write in the back end, so items of any category follow on.
// Reset: statistics and halt cleared, tolerance set to 1, pipeline emptied.
module tolerance_compare_error_stats_unit #(
	parameter int SAMPLE_BITS = tces_pkg::SAMPLE_BITS_DEF,
	parameter int POINT_BITS  = tces_pkg::POINT_BITS_DEF,
	parameter int SUB_BITS    = tces_pkg::SUB_BITS_DEF,
	parameter int QUEUE_DEPTH = tces_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tces_pkg::TOL_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// point_index, sub_index, expected_re, expected_im, actual_re, actual_im,
	// expected_clip, actual_clip, 4 bits zero
	input  logic [tces_pkg::S_TDATA_W-1:0] s_tdata,
	// cmd, category
	input  logic [tces_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status, sample_delta, sample_count, square_sum, has_max, max_delta,
	// max_point, max_sub, max_is_real, max_signed_delta
	output logic [tces_pkg::M_TDATA_W-1:0] m_tdata
);

	logic            fr_valid, fr_ready, bk_valid, bk_ready;
	tces_pkg::item_t fr_item, bk_item;

	tces_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.item_valid(fr_valid),
		.item_ready(fr_ready),
		.item      (fr_item)
	);

	tces_fifo #(
		.WIDTH($bits(tces_pkg::item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(fr_valid),
		.wr_ready(fr_ready),
		.wr_data (fr_item),
		.rd_valid(bk_valid),
		.rd_ready(bk_ready),
		.rd_data (bk_item)
	);

	tces_back #(
		.POINT_BITS(POINT_BITS),
		.SUB_BITS  (SUB_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(bk_valid),
		.item_ready(bk_ready),
		.item      (bk_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
